### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the list store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ils_pkg.sv
// Package of the indexed list store: payload types, codes and default sizes.
package ils_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int MAX_WORD_W     = 64;
    localparam int CMD_W          = 3;
    localparam int POS_W          = 6;
    localparam int VALUE_W        = 32;
    localparam int COUNT_W        = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_POP    = 3'd1,
        CMD_READ   = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_DELETE = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FETCH,
        ST_SHIFT_CHK,
        ST_SHIFT_WR,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] item_value;
    } t_item;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] count_after;
    } t_result;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    typedef struct packed {
        logic busy;
        logic done;
        logic ok;
    } t_status;

endpackage

### rtl/core/ils_mem.sv
// Entry store: one write port and one registered read port.
module ils_mem
    import ils_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int WIDTH = WORD_WIDTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_ctl,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write one entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // register the read beat
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### rtl/core/ils_ctrl.sv
// Sequencer of the list store: length count, shared index step and compare unit.
module ils_ctrl
    import ils_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    localparam int LEN_W  = $clog2(CAPACITY + 1),
    localparam int ADDR_W = $clog2(CAPACITY)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [POS_W-1:0]      i_pos,
    input  logic [WORD_WIDTH-1:0] i_word,
    input  logic [WORD_WIDTH-1:0] i_rdata,
    output t_status               o_status,
    output logic [LEN_W-1:0]      o_len,
    output logic [WORD_WIDTH-1:0] o_value,
    output t_mem_ctl              o_mem_ctl,
    output logic [ADDR_W-1:0]     o_waddr,
    output logic [WORD_WIDTH-1:0] o_wdata,
    output logic [ADDR_W-1:0]     o_raddr
);

    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

    t_state                r_state, n_state;
    logic [LEN_W-1:0]      r_len;
    logic [CMD_W-1:0]      r_cmd;
    logic [POS_W-1:0]      r_pos;
    logic [WORD_WIDTH-1:0] r_word;
    logic [LEN_W-1:0]      r_k;
    logic                  r_ok;
    logic [WORD_WIDTH-1:0] r_value;

    logic                  up;
    logic [LEN_W-1:0]      k_step;
    logic [CMP_W-1:0]      cmp_a, cmp_b;
    logic                  cmp_lt;
    logic [CMP_W-1:0]      pos_ext, len_ext;
    logic                  pos_lt_len, len_lt_cap, len_nz;
    logic                  dec_ok, dec_write, dec_read;
    logic [ADDR_W-1:0]     idx_addr;

    // decode checks on the held command
    assign pos_ext    = CMP_W'(r_pos);
    assign len_ext    = CMP_W'(r_len);
    assign pos_lt_len = (pos_ext < len_ext);
    assign len_lt_cap = (r_len < LEN_W'(CAPACITY));
    assign len_nz     = (r_len != '0);
    assign up         = (r_cmd == CMD_INSERT);
    assign idx_addr   = (r_cmd == CMD_POP) ? '0 : pos_ext[ADDR_W-1:0];

    always_comb begin
        dec_ok    = 1'b0;
        dec_write = 1'b0;
        dec_read  = 1'b0;
        unique case (r_cmd)
            CMD_APPEND: begin
                dec_ok    = len_lt_cap;
                dec_write = len_lt_cap;
            end
            CMD_INSERT: begin
                dec_ok    = len_lt_cap;
                dec_write = len_lt_cap && !pos_lt_len;
            end
            CMD_POP: begin
                dec_ok   = len_nz;
                dec_read = len_nz;
            end
            CMD_READ, CMD_DELETE: begin
                dec_ok   = pos_lt_len;
                dec_read = pos_lt_len;
            end
            default: begin
                dec_ok = 1'b0;
            end
        endcase
    end

    // shared unit: step the index one place and compare against the bound
    always_comb begin
        k_step = up ? (r_k - LEN_W'(1)) : (r_k + LEN_W'(1));
        if (up) begin
            cmp_a = pos_ext;
            cmp_b = CMP_W'(r_k);
        end else begin
            cmp_a = CMP_W'(k_step);
            cmp_b = len_ext;
        end
        cmp_lt = (cmp_a < cmp_b);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (dec_read) begin
                    n_state = ST_FETCH;
                end else if (dec_ok && !dec_write) begin
                    n_state = ST_SHIFT_CHK;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_FETCH: begin
                n_state = (r_cmd == CMD_READ) ? ST_RESP : ST_SHIFT_CHK;
            end
            ST_SHIFT_CHK: begin
                n_state = cmp_lt ? ST_SHIFT_WR : ST_RESP;
            end
            ST_SHIFT_WR: begin
                n_state = ST_SHIFT_CHK;
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs and memory port control
    always_comb begin
        o_mem_ctl = '0;
        o_waddr   = r_k[ADDR_W-1:0];
        o_wdata   = r_word;
        o_raddr   = k_step[ADDR_W-1:0];
        o_status  = '0;
        o_status.busy = (r_state != ST_IDLE);
        o_status.done = (r_state == ST_RESP);
        o_status.ok   = r_ok;
        unique case (r_state)
            ST_DECODE: begin
                o_mem_ctl.wr_en = dec_write;
                o_waddr         = r_len[ADDR_W-1:0];
                o_mem_ctl.rd_en = dec_read;
                o_raddr         = idx_addr;
            end
            ST_SHIFT_CHK: begin
                o_mem_ctl.rd_en = cmp_lt;
                o_mem_ctl.wr_en = !cmp_lt && up;
                o_waddr         = pos_ext[ADDR_W-1:0];
            end
            ST_SHIFT_WR: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wdata         = i_rdata;
            end
            default: begin
                o_mem_ctl = '0;
            end
        endcase
    end

    assign o_len   = r_len;
    assign o_value = r_value;

    // state and length count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DECODE && dec_write) begin
                r_len <= r_len + LEN_W'(1);
            end else if (r_state == ST_SHIFT_CHK && !cmp_lt) begin
                r_len <= up ? (r_len + LEN_W'(1)) : (r_len - LEN_W'(1));
            end
        end
    end

    // hold the command beat and the working index
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_cmd   <= i_cmd;
                    r_pos   <= i_pos;
                    r_word  <= i_word;
                    r_ok    <= 1'b0;
                    r_value <= '0;
                end
            end
            ST_DECODE: begin
                r_ok <= dec_ok;
                r_k  <= up ? r_len : LEN_W'(idx_addr);
            end
            ST_FETCH: begin
                r_value <= i_rdata;
            end
            ST_SHIFT_WR: begin
                r_k <= k_step;
            end
            default: begin
                r_ok <= r_ok;
            end
        endcase
    end

endmodule

### rtl/core/indexed_list_store.sv
// Top level of the indexed list store: payload packing and word sizing.
// One command is taken when start is high and busy is low, and its single
// result appears on o_result with o_done high for one cycle; the receiver
// cannot stall it. The store sits in a memory with one write and one
// registered read port; moving an entry is a read state, then a write
// state. Append, failed and unused commands go from decode to result;
// a read fetches first; insert at p moves entries back from the end to p
// and writes the word (appends if p >= length); pop and delete fetch and
// move later entries forward. The result strobe is in the last busy cycle.
module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNTX_W = (LEN_W > COUNT_W) ? LEN_W : COUNT_W;

    logic [MAX_WORD_W-1:0] item_wide, value_wide;
    logic [WORD_WIDTH-1:0] word, value, rdata, wdata;
    logic [CNTX_W-1:0]     cnt_wide;
    logic [LEN_W-1:0]      len;
    logic [ADDR_W-1:0]     waddr, raddr;
    t_status               status;
    t_mem_ctl              mem_ctl;

    // trim the incoming word to the store width
    assign item_wide = MAX_WORD_W'(i_item.item_value);
    assign word      = item_wide[WORD_WIDTH-1:0];

    ils_ctrl #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_cmd     (i_item.cmd),
        .i_pos     (i_item.position),
        .i_word    (word),
        .i_rdata   (rdata),
        .o_status  (status),
        .o_len     (len),
        .o_value   (value),
        .o_mem_ctl (mem_ctl),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_raddr   (raddr)
    );

    ils_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // pack the result beat
    assign value_wide = MAX_WORD_W'(value);
    assign cnt_wide   = CNTX_W'(len);

    assign busy                 = status.busy;
    assign o_done               = status.done;
    assign o_result.ok          = status.ok;
    assign o_result.read_value  = value_wide[VALUE_W-1:0];
    assign o_result.count_after = cnt_wide[COUNT_W-1:0];

endmodule

### rtl/core/ils_checker.sv
// Port checker of the indexed list store and its bind to the top level.
`include "assert_macros.svh"

module ils_checker
    import ils_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_done,
    input t_result o_result
);

    // a result beat only closes a command in flight
    `ASSERT_CLK(a_done_busy, i_clk, i_rst_n, o_done |-> busy, "result outside a command")

    // an accepted command holds the block off in the next cycle
    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> (busy && !o_done), "accept not followed by busy")

    // one result beat per command
    `ASSERT_CLK(a_done_single, i_clk, i_rst_n, o_done |=> (!o_done && !busy), "result beat repeated")

    // a failed command returns a zero word
    `ASSERT_CLK(a_fail_zero, i_clk, i_rst_n, (o_done && !o_result.ok) |-> (o_result.read_value == '0), "failed result carries data")

endmodule

bind indexed_list_store ils_checker u_ils_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
